// ===== hw/rtl/cp_pkg.sv =====
// Shared types, constants and the arctangent table for the cartesian-to-polar unit.
// Depends on nothing; every other file of the unit refers to it by scoped names.
`default_nettype none

package cp_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int GUARD_BITS     = 16;
    localparam int ROTATION_STEPS = 16;
    localparam int ANGLE_WIDTH    = 16;
    localparam int MAG_WIDTH      = 16;
    localparam int ACC_WIDTH      = 32;
    // Folded coordinates need one bit more than the input; the CORDIC gain needs one more.
    localparam int CORDIC_WIDTH   = COORD_WIDTH + GUARD_BITS + 2;
    localparam int ROOT_WIDTH     = 2 * COORD_WIDTH;
    localparam int ROUND_HALF     = 1 << (ACC_WIDTH - ANGLE_WIDTH - 1);

    localparam logic [ANGLE_WIDTH-1:0] ZERO_TURN          = '0;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN       = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));
    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN          = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 1));
    localparam logic [ANGLE_WIDTH-1:0] THREE_QUARTER_TURN = ANGLE_WIDTH'(3 << (ANGLE_WIDTH - 2));

    // atan(2^-i) / (2*pi) * 2^32, rounded to nearest.
    localparam logic [ACC_WIDTH-1:0] ATAN_TABLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef enum logic [1:0] {
        QUAD_FIRST  = 2'd0,
        QUAD_SECOND = 2'd1,
        QUAD_THIRD  = 2'd2,
        QUAD_FOURTH = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x_coord;
        logic signed [COORD_WIDTH-1:0] y_coord;
    } t_point;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle;
        logic [MAG_WIDTH-1:0]   magnitude;
    } t_polar;

    // Side information that rides along the pipeline untouched.
    typedef struct packed {
        t_quad                  quad;
        logic                   on_axis;
        logic [ANGLE_WIDTH-1:0] axis_angle;
    } t_meta;

    typedef struct packed {
        logic signed [CORDIC_WIDTH-1:0] cx;
        logic signed [CORDIC_WIDTH-1:0] cy;
        logic signed [ACC_WIDTH-1:0]    acc;
        logic [ROOT_WIDTH-1:0]          rem;
        logic [ROOT_WIDTH-1:0]          res;
        t_meta                          meta;
    } t_pipe;

endpackage

`default_nettype wire

// ===== hw/rtl/cp_prep.sv =====
// Front end of the cartesian-to-polar pipeline: quadrant fold, squares and their sum.
// Three register stages. Depends on cp_pkg.
`default_nettype none

module cp_prep (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire cp_pkg::t_point i_point,
    output logic               o_valid,
    output cp_pkg::t_pipe      o_pipe
);

    localparam int W  = cp_pkg::COORD_WIDTH;
    localparam int RW = cp_pkg::ROOT_WIDTH;

    logic signed [W:0] xe;
    logic signed [W:0] ye;
    logic signed [W:0] n_cx;
    logic signed [W:0] n_cy;
    logic [W:0]        ax_full;
    logic [W:0]        ay_full;
    cp_pkg::t_meta     n_meta;

    logic               r1_valid;
    logic [W-1:0]       r1_ax;
    logic [W-1:0]       r1_ay;
    logic signed [W:0]  r1_cx;
    logic signed [W:0]  r1_cy;
    cp_pkg::t_meta      r1_meta;

    logic               r2_valid;
    logic [RW-1:0]      r2_sqx;
    logic [RW-1:0]      r2_sqy;
    logic signed [W:0]  r2_cx;
    logic signed [W:0]  r2_cy;
    cp_pkg::t_meta      r2_meta;

    logic               r3_valid;
    cp_pkg::t_pipe      r3_pipe;

    assign xe      = {i_point.x_coord[W-1], i_point.x_coord};
    assign ye      = {i_point.y_coord[W-1], i_point.y_coord};
    assign ax_full = xe[W] ? (W+1)'(-xe) : xe;
    assign ay_full = ye[W] ? (W+1)'(-ye) : ye;

    // Points on an axis take an exact angle; all others are turned by whole quarter
    // turns into the first quadrant.
    always_comb begin
        n_meta.on_axis    = 1'b0;
        n_meta.axis_angle = cp_pkg::ZERO_TURN;
        if (xe == '0) begin
            n_meta.on_axis    = 1'b1;
            n_meta.axis_angle = ye[W] ? cp_pkg::THREE_QUARTER_TURN : cp_pkg::QUARTER_TURN;
        end else if (ye == '0) begin
            n_meta.on_axis    = 1'b1;
            n_meta.axis_angle = xe[W] ? cp_pkg::HALF_TURN : cp_pkg::ZERO_TURN;
        end

        priority if (!xe[W] && xe != '0 && !ye[W] && ye != '0) begin
            n_meta.quad = cp_pkg::QUAD_FIRST;
            n_cx = xe;
            n_cy = ye;
        end else if (xe[W] && !ye[W] && ye != '0) begin
            n_meta.quad = cp_pkg::QUAD_SECOND;
            n_cx = ye;
            n_cy = -xe;
        end else if (xe[W]) begin
            n_meta.quad = cp_pkg::QUAD_THIRD;
            n_cx = -xe;
            n_cy = -ye;
        end else begin
            n_meta.quad = cp_pkg::QUAD_FOURTH;
            n_cx = -ye;
            n_cy = xe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ax   <= ax_full[W-1:0];
        r1_ay   <= ay_full[W-1:0];
        r1_cx   <= n_cx;
        r1_cy   <= n_cy;
        r1_meta <= n_meta;

        r2_sqx  <= RW'(r1_ax) * RW'(r1_ax);
        r2_sqy  <= RW'(r1_ay) * RW'(r1_ay);
        r2_cx   <= r1_cx;
        r2_cy   <= r1_cy;
        r2_meta <= r1_meta;

        r3_pipe.rem  <= r2_sqx + r2_sqy;
        r3_pipe.res  <= '0;
        r3_pipe.acc  <= '0;
        r3_pipe.cx   <= {r2_cx[W], r2_cx, {cp_pkg::GUARD_BITS{1'b0}}};
        r3_pipe.cy   <= {r2_cy[W], r2_cy, {cp_pkg::GUARD_BITS{1'b0}}};
        r3_pipe.meta <= r2_meta;
    end

    assign o_valid = r3_valid;
    assign o_pipe  = r3_pipe;

endmodule

`default_nettype wire

// ===== hw/rtl/cp_stage.sv =====
// One pipeline stage: a CORDIC vectoring iteration and one bit of the square root.
// Each half switches itself off past its own step count. Depends on cp_pkg.
`default_nettype none

module cp_stage #(
    parameter int STEP_IDX  = 0,
    parameter int ROT_STEPS = cp_pkg::ROTATION_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire cp_pkg::t_pipe i_pipe,
    output logic               o_valid,
    output cp_pkg::t_pipe      o_pipe
);

    localparam int  W         = cp_pkg::COORD_WIDTH;
    localparam int  RW        = cp_pkg::ROOT_WIDTH;
    localparam int  CW        = cp_pkg::CORDIC_WIDTH;
    localparam bit  DO_CORDIC = (STEP_IDX < ROT_STEPS);
    localparam bit  DO_ROOT   = (STEP_IDX < W);
    localparam int  ROOT_K    = DO_ROOT ? (W - 1 - STEP_IDX) : 0;
    localparam logic [RW-1:0] ROOT_BIT = RW'(1) << (2 * ROOT_K);
    localparam logic [cp_pkg::ACC_WIDTH-1:0] ATAN_I = cp_pkg::ATAN_TABLE[STEP_IDX];

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic [RW-1:0]        trial;
    cp_pkg::t_pipe        n_pipe;
    logic                 r_valid;
    cp_pkg::t_pipe        r_pipe;

    assign dx    = i_pipe.cy >>> STEP_IDX;
    assign dy    = i_pipe.cx >>> STEP_IDX;
    assign trial = i_pipe.res + ROOT_BIT;

    always_comb begin
        n_pipe = i_pipe;
        if (DO_CORDIC) begin
            if (!i_pipe.cy[CW-1]) begin
                n_pipe.cx  = i_pipe.cx + dx;
                n_pipe.cy  = i_pipe.cy - dy;
                n_pipe.acc = i_pipe.acc + $signed(ATAN_I);
            end else begin
                n_pipe.cx  = i_pipe.cx - dx;
                n_pipe.cy  = i_pipe.cy + dy;
                n_pipe.acc = i_pipe.acc - $signed(ATAN_I);
            end
        end
        if (DO_ROOT) begin
            if (i_pipe.rem >= trial) begin
                n_pipe.rem = i_pipe.rem - trial;
                n_pipe.res = (i_pipe.res >> 1) + ROOT_BIT;
            end else begin
                n_pipe.res = i_pipe.res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe <= n_pipe;
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

`default_nettype wire

// ===== hw/rtl/cp_final.sv =====
// Back end of the cartesian-to-polar pipeline: angle rounding, quadrant offset, root rounding.
// One register stage driving the result strobe. Depends on cp_pkg.
`default_nettype none

module cp_final (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire cp_pkg::t_pipe i_pipe,
    output logic               o_valid,
    output cp_pkg::t_polar     o_polar
);

    localparam int AW = cp_pkg::ACC_WIDTH;
    localparam int RW = cp_pkg::ROOT_WIDTH;
    localparam int NW = cp_pkg::ANGLE_WIDTH;

    logic signed [AW:0]  acc_round;
    logic [NW-1:0]       frac;
    logic [NW-1:0]       quad_base;
    logic [RW-1:0]       root;
    cp_pkg::t_polar      n_polar;
    logic                r_valid;
    cp_pkg::t_polar      r_polar;

    assign acc_round = {i_pipe.acc[AW-1], i_pipe.acc} + (AW+1)'(cp_pkg::ROUND_HALF);
    assign frac      = acc_round[AW-1:AW-NW];
    assign quad_base = {i_pipe.meta.quad, {(NW-2){1'b0}}};
    // A remainder above the root means the true root lies past the half-way point.
    assign root      = (i_pipe.rem > i_pipe.res) ? (i_pipe.res + RW'(1)) : i_pipe.res;

    always_comb begin
        n_polar.angle     = i_pipe.meta.on_axis ? i_pipe.meta.axis_angle : (quad_base + frac);
        n_polar.magnitude = root[cp_pkg::MAG_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_polar <= n_polar;
    end

    assign o_valid = r_valid;
    assign o_polar = r_polar;

endmodule

`default_nettype wire

// ===== hw/rtl/cartesian_to_polar_unit.sv =====
// Top level of the cartesian-to-polar unit: front end, iteration stages and back end.
// Depends on cp_pkg, cp_prep, cp_stage and cp_final.
`default_nettype none

// Usage
// A point (x_coord, y_coord) is transferred in at each rising edge where start is high
// and busy is low. The unit never holds a transfer off, so busy stays low and a new
// point may be offered in every cycle.
// Each result (angle, magnitude) appears on o_polar for exactly one cycle, marked by
// o_valid, and the receiver must take it in that cycle; there is no back-pressure.
// There are ROTATION_STEPS-or-coordinate-width stages plus four: three front-end
// stages (quadrant fold, squaring, sum), one stage per CORDIC iteration and root bit
// (the larger of ROTATION_STEPS and the coordinate width, 16 by default), and one
// output stage. Throughput is one point per cycle, set by the fully unrolled chain of
// iteration stages.
// Results leave in the order the points arrived.
// A synchronous reset clears every valid bit in the pipeline, so points in flight are
// dropped and no strobe follows until new points are transferred in.
module cartesian_to_polar_unit #(
    parameter int ROTATION_STEPS = cp_pkg::ROTATION_STEPS
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire cp_pkg::t_point i_point,
    output logic                o_valid,
    output cp_pkg::t_polar      o_polar
);

    // Each stage carries one CORDIC iteration and one root bit side by side, each half only while its step count lasts.
    localparam int STAGES  = (ROTATION_STEPS > cp_pkg::COORD_WIDTH)
                             ? ROTATION_STEPS : cp_pkg::COORD_WIDTH;
    localparam int LATENCY = STAGES + 4;

    logic [STAGES:0] stage_valid;
    cp_pkg::t_pipe   stage_pipe [STAGES+1];

    assign busy = 1'b0;

    cp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_point (i_point),
        .o_valid (stage_valid[0]),
        .o_pipe  (stage_pipe[0])
    );

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        cp_stage #(
            .STEP_IDX  (g),
            .ROT_STEPS (ROTATION_STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[g]),
            .i_pipe  (stage_pipe[g]),
            .o_valid (stage_valid[g+1]),
            .o_pipe  (stage_pipe[g+1])
        );
    end

    cp_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[STAGES]),
        .i_pipe  (stage_pipe[STAGES]),
        .o_valid (o_valid),
        .o_polar (o_polar)
    );

`ifndef ASSERT_OFF
    // Every transfer in gives exactly one strobe.
    a_latency_fwd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("point transferred in gave no result at the expected latency");

    a_latency_back : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, LATENCY)) |-> $past(start, LATENCY))
        else $error("result strobe without a matching input transfer");

    a_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_point.x_coord == '0 && i_point.y_coord == '0)
        |-> ##LATENCY (o_polar.magnitude == '0 && o_polar.angle == cp_pkg::QUARTER_TURN))
        else $error("origin did not map to a quarter turn with zero length");

    a_neg_x_axis : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_point.y_coord == '0 && i_point.x_coord[cp_pkg::COORD_WIDTH-1])
        |-> ##LATENCY (o_polar.angle == cp_pkg::HALF_TURN))
        else $error("point on the negative x axis did not give a half turn");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for cartesian_to_polar_unit: directed points, then random ones.
// Depends on cp_pkg for the point and polar types and the quadrant enum.
`default_nettype none

module tb_top;

    // Angles in units of 1/65536 turn, and the arctangents of 2^-i in units of 2^-32 turn.
    localparam logic [15:0] TURN_QUARTER       = 16'd16384;
    localparam logic [15:0] TURN_HALF          = 16'd32768;
    localparam logic [15:0] TURN_THREE_QUARTER = 16'd49152;
    localparam int          FRACTION_BITS      = 16;
    localparam int          CORDIC_STEPS       = 16;
    localparam int          DRAIN_CYCLES       = 40;
    localparam int          STALL_LIMIT        = 2000;
    localparam int          RANDOM_POINTS      = 800;

    localparam longint ARCTAN_TURNS [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    cp_pkg::t_point i_point;
    logic           o_valid;
    cp_pkg::t_polar o_polar;

    // Results that accepted points are owed, oldest first.
    cp_pkg::t_polar pending_polar [$];
    int     mismatch_count;
    int     stall_cycles;
    // When set, the sender offers points back to back with no idle cycles.
    bit     burst_mode;

    cartesian_to_polar_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_point (i_point),
        .o_valid (o_valid),
        .o_polar (o_polar)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Rounded square root: floor root by the bit-pair method, then bumped up by one when
    // the remainder exceeds the root, which is where n lies past (s + 1/2)^2.
    function automatic longint nearest_root(longint n);
        longint root_acc;
        longint bit_weight;
        longint remainder;
        root_acc   = 0;
        bit_weight = longint'(1) << 62;
        remainder  = n;
        while (bit_weight > remainder) begin
            bit_weight = bit_weight >> 2;
        end
        while (bit_weight != 0) begin
            if (remainder >= root_acc + bit_weight) begin
                remainder = remainder - (root_acc + bit_weight);
                root_acc  = (root_acc >> 1) + bit_weight;
            end else begin
                root_acc = root_acc >> 1;
            end
            bit_weight = bit_weight >> 2;
        end
        if (remainder > root_acc) begin
            root_acc = root_acc + 1;
        end
        return root_acc;
    endfunction

    // Expected angle and magnitude of one point. Off-axis points are folded into the
    // open first quadrant by quarter turns, and the CORDIC vectoring chain drives the
    // folded y towards zero while it sums the arctangents of the steps it takes.
    function automatic cp_pkg::t_polar polar_of(cp_pkg::t_point p);
        longint x;
        longint y;
        longint ax;
        longint ay;
        longint cx;
        longint cy;
        longint dx;
        longint dy;
        longint turns;
        cp_pkg::t_quad  quad;
        cp_pkg::t_polar r;
        x  = longint'($signed(p.x_coord));
        y  = longint'($signed(p.y_coord));
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r.magnitude = 16'(nearest_root(ax * ax + ay * ay));
        if (x == 0) begin
            r.angle = (y >= 0) ? TURN_QUARTER : TURN_THREE_QUARTER;
        end else if (y == 0) begin
            r.angle = (x > 0) ? 16'd0 : TURN_HALF;
        end else begin
            if (x > 0 && y > 0) begin
                quad = cp_pkg::QUAD_FIRST;
                cx = x;
                cy = y;
            end else if (x < 0 && y > 0) begin
                quad = cp_pkg::QUAD_SECOND;
                cx = y;
                cy = -x;
            end else if (x < 0) begin
                quad = cp_pkg::QUAD_THIRD;
                cx = -x;
                cy = -y;
            end else begin
                quad = cp_pkg::QUAD_FOURTH;
                cx = -y;
                cy = x;
            end
            cx    = cx <<< FRACTION_BITS;
            cy    = cy <<< FRACTION_BITS;
            turns = 0;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                // Arithmetic shifts of signed values round towards minus infinity.
                dx = cy >>> i;
                dy = cx >>> i;
                if (cy >= 0) begin
                    cx    = cx + dx;
                    cy    = cy - dy;
                    turns = turns + ARCTAN_TURNS[i];
                end else begin
                    cx    = cx - dx;
                    cy    = cy + dy;
                    turns = turns - ARCTAN_TURNS[i];
                end
            end
            turns = (turns + 32768) >>> 16;
            // Truncation to 16 bits wraps an angle that rounds up to a full turn to zero.
            r.angle = 16'(longint'(quad) * 16384 + turns);
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input cp_pkg::t_polar want,
                                 input cp_pkg::t_polar got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected angle %0d magnitude %0d, got angle %0d magnitude %0d",
                     what, want.angle, want.magnitude, got.angle, got.magnitude);
        end
    endtask

    // Prediction on every input transfer, and comparison on every result strobe. The
    // unit registers each point through its pipeline, so a result never meets its own prediction here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                if (pending_polar.size() == 0) begin
                    note_mismatch("unexpected result", '0, o_polar);
                end else begin
                    if (o_polar.angle !== pending_polar[0].angle ||
                        o_polar.magnitude !== pending_polar[0].magnitude) begin
                        note_mismatch("result mismatch", pending_polar[0], o_polar);
                    end
                    void'(pending_polar.pop_front());
                end
            end
            if (start && !busy) begin
                pending_polar.insert(pending_polar.size(), polar_of(i_point));
            end
        end
    end

    // The watchdog counts cycles in which no transfer takes place in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("cartesian_to_polar_unit test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Mostly no gap or a short one, now and then a long one; none at all in burst mode.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (burst_mode || pick < 50) begin
            return 0;
        end else if (pick < 85) begin
            return $urandom_range(1, 3);
        end else if (pick < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    // Offers one point and returns once its transfer has taken place. Start stays high
    // afterwards, so the next call may follow on without an idle cycle. During a gap the
    // point lines carry rubbish, which the unit must ignore.
    task automatic send_point(input cp_pkg::t_point p);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start   = 1'b0;
            i_point = cp_pkg::t_point'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start   = 1'b1;
        i_point = p;
        do begin
            @(posedge i_clk);
        end while (busy);
    endtask

    task automatic send_xy(input int x, input int y);
        cp_pkg::t_point p;
        p.x_coord = 16'(x);
        p.y_coord = 16'(y);
        send_point(p);
    endtask

    // The origin and the four half axes, each at its extreme and next to the origin.
    task automatic test_origin_and_axes();
        send_xy(0, 0);
        send_xy(0, 32767);
        send_xy(0, -32768);
        send_xy(0, 1);
        send_xy(0, -1);
        send_xy(32767, 0);
        send_xy(-32768, 0);
        send_xy(1, 0);
        send_xy(-1, 0);
    endtask

    // One diagonal point in each quadrant, so every fold is taken once.
    task automatic test_quadrant_diagonals();
        send_xy(1, 1);
        send_xy(-1, 1);
        send_xy(-1, -1);
        send_xy(1, -1);
    endtask

    // The four corners of the coordinate range, which give the largest magnitudes.
    task automatic test_range_corners();
        send_xy(32767, 32767);
        send_xy(-32768, 32767);
        send_xy(-32768, -32768);
        send_xy(32767, -32768);
    endtask

    // Points just below the positive x axis, whose angle rounds towards a full turn
    // and must wrap, and points just off the negative x and y axes.
    task automatic test_turn_wrap();
        send_xy(32767, -1);
        send_xy(30000, -1);
        send_xy(-32768, -1);
        send_xy(1, -32768);
    endtask

    // Random points: mostly the full range, with extra weight on small coordinates,
    // on the axes and on the edges of the range. Bursts without gaps come and go.
    task automatic test_random_points();
        int pick;
        int x;
        int y;
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            if (n % 50 == 0) begin
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
            if (pick < 15) begin
                x = $urandom_range(0, 16) - 8;
                y = $urandom_range(0, 16) - 8;
            end else if (pick < 25) begin
                if ($urandom_range(0, 1) == 1) begin
                    x = 0;
                end else begin
                    y = 0;
                end
            end else if (pick < 40) begin
                x = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                if ($urandom_range(0, 1) == 1) begin
                    y = x;
                    x = $signed(16'($urandom));
                end
            end
            send_xy(x, y);
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_point        = '0;
        mismatch_count = 0;
        stall_cycles   = 0;
        burst_mode     = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_origin_and_axes();
        test_quadrant_diagonals();
        test_range_corners();
        test_turn_wrap();
        test_random_points();

        @(negedge i_clk);
        start = 1'b0;

        // Wait for every owed result, then a little longer to catch any stray strobe.
        while (pending_polar.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("cartesian_to_polar_unit test passed");
        end else begin
            $display("cartesian_to_polar_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/cp_pkg.sv
hw/rtl/cp_prep.sv
hw/rtl/cp_stage.sv
hw/rtl/cp_final.sv
hw/rtl/cartesian_to_polar_unit.sv
verif/tb_top.sv
